// ----- sv/poll_pkg.sv -----
// ----------------------------------------------------------------------------
// Positional ordered list: shared types and constants
// Operation and status codes, the request and response transfers, and the
// per-cell control word used along the chain of storage cells.
// ----------------------------------------------------------------------------
package poll_pkg;

  // Number of storage cells in the chain.
  localparam int CAPACITY = 16;

  // Field widths fixed by the interface.
  localparam int OP_W  = 2;
  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int LEN_W = 5;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // Status codes.
  typedef enum logic [ST_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // One request transfer.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  // One response transfer.
  typedef struct packed {
    logic [ST_W-1:0]         status;
    logic signed [VAL_W-1:0] value_out;
    logic [LEN_W-1:0]        length;
  } rsp_t;

  // Per-cell load control: at most one of these is set in a cycle.
  typedef struct packed {
    logic load_new;   // take the inserted value
    logic take_left;  // take the lower neighbour's value (insert shift)
    logic take_right; // take the upper neighbour's value (remove shift)
  } cell_ctl_t;

endpackage

// ----- sv/poll_cell.sv -----
// ----------------------------------------------------------------------------
// Positional ordered list: storage cell
// Holds one entry of the list and loads either the new value or one of its
// neighbours' values when the chain shifts.
// ----------------------------------------------------------------------------
module poll_cell (
  input  logic                             clk,
  input  poll_pkg::cell_ctl_t              ctl,
  input  logic signed [poll_pkg::VAL_W-1:0] new_value,
  input  logic signed [poll_pkg::VAL_W-1:0] left_value,
  input  logic signed [poll_pkg::VAL_W-1:0] right_value,
  output logic signed [poll_pkg::VAL_W-1:0] value
);
  import poll_pkg::*;

  // Entry register; its contents are only meaningful once written.
  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      value <= new_value;
    end else if (ctl.take_left) begin
      value <= left_value;
    end else if (ctl.take_right) begin
      value <= right_value;
    end
  end

endmodule

// ----- sv/positional_ordered_list_top.sv -----
// ----------------------------------------------------------------------------
// Positional ordered list: top level
// An ordered list of signed 32-bit values kept in a chain of cells, with
// insert, remove and read at a given position.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries one operation per transfer (op, position,
//   item_value). The rsp channel returns exactly one result per request:
//   status, the removed or read value (zero otherwise) and the list length
//   after the operation.
//   Every cell compares its own index with the position and loads its new
//   value, a neighbour's value or nothing in the same cycle, so the whole
//   shift of an insert or remove is done at the clock edge that takes the request.
//   Throughput: one request per cycle while req_stall is low. The result is
//   registered and appears in the cycle after the request transfer.
//   The response register is single-entry: while a result waits and rsp_stall
//   is high, req_stall is raised and no further request is taken; when the
//   result is taken, a new request is accepted in the same cycle.
//   Reset (rst, synchronous, active high) empties the list and drops any
//   pending result. Entries hold no reset value; only positions below the
//   current length are ever returned.
// ----------------------------------------------------------------------------
module positional_ordered_list_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  poll_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output poll_pkg::rsp_t  rsp
);
  import poll_pkg::*;

  logic [LEN_W-1:0]         count;
  logic [LEN_W-1:0]         count_next;
  logic                     accept;
  logic                     is_insert;
  logic                     is_remove;
  logic                     is_read;
  logic                     full;
  logic                     ok;
  logic [POS_W-1:0]         pos_eff;
  logic [ST_W-1:0]          status_next;
  logic signed [VAL_W-1:0]  sel_value;
  logic signed [VAL_W-1:0]  cell_value [CAPACITY];
  logic signed [VAL_W-1:0]  sel_term   [CAPACITY];
  cell_ctl_t                cell_ctl   [CAPACITY];
  rsp_t                     rsp_next;

  // Request transfer: taken whenever the response register is free or drains.
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  // Decode the operation and check it against the current length.
  assign is_insert = (req.op == OP_INSERT);
  assign is_remove = (req.op == OP_REMOVE);
  assign is_read   = (req.op == OP_READ);
  assign full      = (count == LEN_W'(CAPACITY));

  always_comb begin
    pos_eff     = req.position;
    ok          = 1'b0;
    status_next = ST_BAD;
    if (is_insert) begin
      if (count == '0) begin
        pos_eff = '0;
      end
      if (full) begin
        status_next = ST_FULL;
      end else if (count == '0 || req.position <= POS_W'(count)) begin
        ok          = 1'b1;
        status_next = ST_DONE;
      end
    end else if (is_remove || is_read) begin
      if (req.position < POS_W'(count)) begin
        ok          = 1'b1;
        status_next = ST_DONE;
      end
    end
  end

  // The chain of cells: each cell decides its own load from its index.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_value;
    logic signed [VAL_W-1:0] right_value;

    assign cell_ctl[i].load_new   = accept && ok && is_insert && (pos_eff == POS_W'(i));
    assign cell_ctl[i].take_left  = accept && ok && is_insert && (pos_eff < POS_W'(i));
    assign cell_ctl[i].take_right = accept && ok && is_remove && (pos_eff <= POS_W'(i));

    if (i == 0) begin : g_first
      assign left_value = '0;
    end else begin : g_inner_left
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_value = '0;
    end else begin : g_inner_right
      assign right_value = cell_value[i+1];
    end

    poll_cell u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .new_value   (req.item_value),
      .left_value  (left_value),
      .right_value (right_value),
      .value       (cell_value[i])
    );

    // Each cell puts its value on the read bus only when addressed.
    assign sel_term[i] = (req.position == POS_W'(i)) ? cell_value[i] : '0;
  end

  // OR together the addressed cell's value.
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_value = sel_value | sel_term[i];
    end
  end

  // Length update and the result for this request.
  always_comb begin
    count_next = count;
    if (ok && is_insert) begin
      count_next = count + LEN_W'(1);
    end else if (ok && is_remove) begin
      count_next = count - LEN_W'(1);
    end
    rsp_next.status    = status_next;
    rsp_next.value_out = (ok && (is_remove || is_read)) ? sel_value : '0;
    rsp_next.length    = count_next;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // While a response is valid, its reported length matches the stored length.
  a_len_matches: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.length == count))
    else $error("reported length differs from stored length");

  // The length never exceeds the capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    count <= LEN_W'(CAPACITY))
    else $error("length exceeds capacity");

  // A full status is only given with a full list and no value.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == ST_FULL) |->
      (rsp.length == LEN_W'(CAPACITY) && rsp.value_out == '0))
    else $error("full status with a list that is not full");

  // A rejected request leaves the length unchanged.
  a_bad_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (accept && status_next != ST_DONE) |=> (count == $past(count)))
    else $error("rejected request changed the length");

endmodule

// ----- tb/list_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional ordered list: result checker
// Watches the request and response channels of the list. It keeps a shadow
// copy of the sequence, works out the response to every accepted request
// and compares each accepted response with the oldest one still waiting.
// ----------------------------------------------------------------------------
module list_result_checker
  import poll_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  output int unsigned failures,
  output int unsigned outstanding,
  output int unsigned list_length
);

  // Shadow copy of the list contents and its length.
  logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
  int unsigned             shadow_len;

  // Responses predicted but not yet seen, oldest first.
  rsp_t pending_results [$];
  rsp_t want;
  rsp_t predicted;

  // Applies one operation to the shadow list and works out its response.
  task automatic apply_list_op(input req_t r, output rsp_t result);
    int unsigned at;
    int unsigned k;
    begin
      result           = '0;
      result.status    = ST_BAD;
      result.value_out = '0;
      at               = 32'(r.position);
      case (r.op)
        OP_INSERT: begin
          if (shadow_len >= CAPACITY) begin
            result.status = ST_FULL;
          end else begin
            // An empty list always takes the value at the front.
            if (shadow_len == 0) at = 0;
            if (at <= shadow_len) begin
              for (k = shadow_len; k > at; k--) shadow_entries[k] = shadow_entries[k-1];
              shadow_entries[at] = r.item_value;
              shadow_len++;
              result.status = ST_DONE;
            end
          end
        end
        OP_REMOVE: begin
          if (at < shadow_len) begin
            result.value_out = shadow_entries[at];
            for (k = at; k + 1 < shadow_len; k++) shadow_entries[k] = shadow_entries[k+1];
            shadow_len--;
            result.status = ST_DONE;
          end
        end
        OP_READ: begin
          if (at < shadow_len) begin
            result.value_out = shadow_entries[at];
            result.status    = ST_DONE;
          end
        end
        default: begin
          // Unknown operation: rejected, nothing changes.
        end
      endcase
      result.length = LEN_W'(shadow_len);
    end
  endtask

  // Response transfers are checked before the request of the same edge is
  // predicted, since a response always belongs to an earlier request.
  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      shadow_len = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (pending_results.size() == 0) begin
          $error("response transfer with no request waiting: status %0d value %0d length %0d",
                 rsp.status, $signed(rsp.value_out), rsp.length);
          failures <= failures + 1;
        end else begin
          want = pending_results.pop_front();
          if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
              rsp.length !== want.length) begin
            failures <= failures + 1;
          end
          if (rsp.status !== want.status)
            $error("status: expected %0d, got %0d", want.status, rsp.status);
          if (rsp.value_out !== want.value_out)
            $error("value_out: expected %0d, got %0d",
                   $signed(want.value_out), $signed(rsp.value_out));
          if (rsp.length !== want.length)
            $error("length: expected %0d, got %0d", want.length, rsp.length);
        end
      end
      if (req_valid && !req_stall) begin
        apply_list_op(req, predicted);
        pending_results.push_back(predicted);
      end
    end
    // Registered copies of the queue size and shadow length for the stimulus side.
    outstanding <= pending_results.size();
    list_length <= shadow_len;
  end

endmodule

// ----- tb/positional_ordered_list_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional ordered list: testbench top
// Drives insert, remove and read requests into the list, first a directed
// sequence through the edge cases and then random traffic that grows and
// shrinks the list, under three patterns of sender and receiver idling.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module positional_ordered_list_top_test;
  import poll_pkg::*;

  // Operation code outside the defined set.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  localparam int RANDOM_PER_PHASE = 642;
  localparam int SWING_SPAN       = 48;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  int unsigned failures;
  int unsigned outstanding;
  int unsigned list_length;

  int unsigned send_idle_pct = 25;
  int unsigned recv_stall_pct = 75;

  positional_ordered_list_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  list_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .failures    (failures),
    .outstanding (outstanding),
    .list_length (list_length)
  );

  // Clock generation.
  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offers one request, after a random idle gap, and holds it until transfer.
  task automatic send_op(input logic [OP_W-1:0] op, input int unsigned pos,
                         input logic [VAL_W-1:0] val);
    begin
      while ($urandom_range(99) < send_idle_pct) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
      req_valid       <= 1'b1;
      req.op          <= op;
      req.position    <= POS_W'(pos);
      req.item_value  <= val;
      @(posedge clk);
      while (req_stall) @(posedge clk);
    end
  endtask

  // Random traffic that swings between growing and shrinking the list.
  task automatic run_random(input int count);
    int                 n;
    int unsigned        pick;
    int unsigned        len;
    int unsigned        pos;
    logic [OP_W-1:0]    op;
    logic [VAL_W-1:0]   val;
    bit                 grow;
    begin
      grow = 1'b1;
      for (n = 0; n < count; n++) begin
        if (n % SWING_SPAN == 0) grow = $urandom_range(1);
        len  = list_length;
        pick = $urandom_range(99);
        if (pick < 3) op = OP_UNKNOWN;
        else if (pick < (grow ? 63 : 28)) op = OP_INSERT;
        else if (pick < 80) op = OP_REMOVE;
        else op = OP_READ;
        // Mostly positions that the list can act on, with some noise.
        if ($urandom_range(99) < 10) pos = $urandom_range(31);
        else if (op == OP_INSERT) pos = $urandom_range(len);
        else pos = (len == 0) ? 0 : $urandom_range(len - 1);
        pick = $urandom_range(99);
        if (pick < 5) val = 32'h8000_0000;
        else if (pick < 10) val = 32'h7fff_ffff;
        else val = $urandom();
        send_op(op, pos, val);
      end
    end
  endtask

  // Main stimulus.
  initial begin : stimulus
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty list, front, back and middle inserts, rejects.
    send_op(OP_READ,    0, 32'd0);
    send_op(OP_REMOVE,  0, 32'd0);
    send_op(OP_INSERT,  7, 32'h8000_0000);
    send_op(OP_INSERT,  5, 32'h1234_5678);
    send_op(OP_INSERT,  1, 32'h7fff_ffff);
    send_op(OP_INSERT,  0, 32'hffff_ffff);
    send_op(OP_INSERT,  1, 32'h5555_aaaa);
    send_op(OP_UNKNOWN, 1, 32'hdead_beef);
    send_op(OP_READ,   31, 32'd0);
    send_op(OP_REMOVE,  4, 32'd0);
    send_op(OP_READ,    0, 32'd0);
    send_op(OP_READ,    3, 32'd0);
    for (k = 4; k < CAPACITY; k++) send_op(OP_INSERT, k, $urandom());
    send_op(OP_INSERT, 16, 32'h0bad_0bad);
    send_op(OP_REMOVE, 15, 32'd0);
    send_op(OP_REMOVE,  0, 32'd0);

    // Random part under three idling patterns.
    run_random(RANDOM_PER_PHASE);
    send_idle_pct  = 75;
    recv_stall_pct = 25;
    run_random(RANDOM_PER_PHASE);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_PER_PHASE);
    req_valid <= 1'b0;

    // Drain the remaining responses, then allow for the response latency.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/poll_pkg.sv
sv/poll_cell.sv
sv/positional_ordered_list_top.sv
tb/list_result_checker.sv
tb/positional_ordered_list_top_test.sv
